// ----- rtl/ircrt_pkg.sv -----
// Shared types and constants for the IR code route table.
// Holds the input/output beat structs, the queue item, and the state enum.
// No dependencies; every other file in rtl/ imports this package.
package ircrt_pkg;

    localparam int ROUTE_CAPACITY_DEF = 64;
    localparam int MAX_RESULTS        = 64;
    localparam int RES_W              = $clog2(MAX_RESULTS + 1);

    // Command queue between the front and back sections.
    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = 1;
    localparam int QC_W        = 2;

    // Command codes on the input beat.
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_BEGIN  = 2'd1;
    localparam logic [1:0] CMD_ENTRY  = 2'd2;
    localparam logic [1:0] CMD_RSVD   = 2'd3;

    // Action codes on the output beat.
    localparam logic [1:0] ACT_LOCAL  = 2'd0;
    localparam logic [1:0] ACT_REMOTE = 2'd1;
    localparam logic [1:0] ACT_REJECT = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] route_count;
        logic [31:0] src_protocol;
        logic [63:0] src_code;
        logic [31:0] dst_protocol;
        logic [63:0] dst_code;
        logic [31:0] dst_ip;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] out_protocol;
        logic [63:0] out_code;
        logic [31:0] out_address;
        logic        last;
    } t_out_item;

    // One route as stored in the table memory.
    typedef struct packed {
        logic [31:0] src_protocol;
        logic [63:0] src_code;
        logic [31:0] dst_protocol;
        logic [63:0] dst_code;
        logic [31:0] dst_address;
    } t_route;

    // Command class decided by the front section.
    typedef enum logic [2:0] {
        K_LOOKUP,
        K_BEGIN,
        K_CLEAR,
        K_REJECT,
        K_ENTRY
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] route_count;
        t_route      route;
    } t_q_item;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_FLUSH,
        BK_REJECT
    } t_back_state;

endpackage

// ----- rtl/ir_code_route_table_unit.sv -----
// IR code route table top level: front classifier, command queue, table back end.
// Depends on ircrt_pkg, ircrt_front and ircrt_back.
// A beat is queued at its accepting edge; the back end applies a load beat when it
// pops it, which waits while a lookup or refused count is still in progress. A
// lookup reads one active route per cycle unless a held match cannot leave, compares
// it, holds one match back and passes results through the output register. The back
// end takes one load beat per cycle while idle. Reset (synchronous, active low)
// empties the queue and clears all counts; routes stay undefined until loaded.
module ir_code_route_table_unit import ircrt_pkg::*; #(
    parameter int ROUTE_CAPACITY = ROUTE_CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    // The front takes a beat whenever the two-entry queue has room, so
    // load beats can stack up while a lookup is still streaming results.
    // The back drains the queue one command at a time; a lookup walks the
    // table in order and holds one match back so the final one can be
    // marked last. Results leave through a registered output beat.
    logic    q_valid;
    logic    q_pop;
    t_q_item q_item;

    ircrt_front #(
        .ROUTE_CAPACITY (ROUTE_CAPACITY)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (i_item),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop),
        .o_q_item  (q_item)
    );

    ircrt_back #(
        .ROUTE_CAPACITY (ROUTE_CAPACITY)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_item)
    );

endmodule

// ----- rtl/ircrt_front.sv -----
// Front section: accepts input beats, classifies the command and queues it.
// Depends on ircrt_pkg for the beat, queue item and command codes.
module ircrt_front import ircrt_pkg::*; #(
    parameter int ROUTE_CAPACITY = ROUTE_CAPACITY_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_q_valid,
    input  logic     i_q_pop,
    output t_q_item  o_q_item
);

    t_q_item          r_q [QUEUE_DEPTH];
    logic [QP_W-1:0]  r_wr_ptr;
    logic [QP_W-1:0]  r_rd_ptr;
    logic [QC_W-1:0]  r_cnt;
    t_q_item          n_item;
    logic             push;
    logic             pop;

    assign o_ready   = (r_cnt != QC_W'(QUEUE_DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rd_ptr];

    // The reserved command is taken and dropped here.
    assign push = i_valid && o_ready && (i_item.command != CMD_RSVD);
    assign pop  = i_q_pop && o_q_valid;

    always_comb begin
        n_item.route_count        = i_item.route_count;
        n_item.route.src_protocol = i_item.src_protocol;
        n_item.route.src_code     = i_item.src_code;
        n_item.route.dst_protocol = i_item.dst_protocol;
        n_item.route.dst_code     = i_item.dst_code;
        n_item.route.dst_address  = i_item.dst_ip;
        priority if (i_item.command == CMD_BEGIN) begin
            if (i_item.route_count > 16'(ROUTE_CAPACITY)) begin
                n_item.kind = K_REJECT;
            end else if (i_item.route_count == '0) begin
                n_item.kind = K_CLEAR;
            end else begin
                n_item.kind = K_BEGIN;
            end
        end else if (i_item.command == CMD_ENTRY) begin
            n_item.kind = K_ENTRY;
        end else begin
            n_item.kind = K_LOOKUP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_item;
        end
    end

endmodule

// ----- rtl/ircrt_back.sv -----
// Back section: route table memory, load bookkeeping and the lookup walker.
// Depends on ircrt_pkg for the route, queue item, output beat and state enum.
module ircrt_back import ircrt_pkg::*; #(
    parameter int ROUTE_CAPACITY = ROUTE_CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_q_item   i_q_item,
    output logic      o_q_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam int CNT_W = $clog2(ROUTE_CAPACITY + 1);
    localparam int IDX_W = (ROUTE_CAPACITY > 1) ? $clog2(ROUTE_CAPACITY) : 1;

    t_back_state      r_state;
    t_back_state      n_state;
    logic [CNT_W-1:0] r_active;
    logic [CNT_W-1:0] r_pend;
    logic [CNT_W-1:0] r_wptr;
    logic             r_loading;
    t_route           r_mem [ROUTE_CAPACITY];
    logic [CNT_W-1:0] r_idx;
    t_route           r_rd;
    logic             r_rd_vld;
    logic [31:0]      r_key_protocol;
    logic [63:0]      r_key_code;
    t_out_item        r_hold;
    logic             r_hold_vld;
    logic [RES_W-1:0] r_nres;
    t_out_item        r_out;
    logic             r_out_vld;

    logic             out_free;
    logic             cmp_match;
    logic             walk_adv;
    logic             rd_issue;
    logic             cap_hit;
    logic             walk_done;
    logic             push_hold;
    logic             flush_out;
    logic             reject_out;
    logic             start_walk;
    logic             do_begin;
    logic             do_clear;
    logic             do_entry;
    logic [CNT_W-1:0] wptr_inc;
    t_out_item        match_res;

    assign o_valid  = r_out_vld;
    assign o_item   = r_out;
    assign out_free = !r_out_vld || i_ready;
    assign wptr_inc = r_wptr + 1'b1;

    // Compare stage works on the entry held in the registered read port.
    assign cmp_match = r_rd_vld
                    && (r_rd.src_protocol == r_key_protocol)
                    && (r_rd.src_code == r_key_code)
                    && (r_rd.dst_protocol != '0);
    assign cap_hit   = cmp_match && (r_nres == RES_W'(MAX_RESULTS - 1));
    assign walk_done = !r_rd_vld && (r_idx >= r_active);

    always_comb begin
        match_res.action       = (r_rd.dst_address == '0) ? ACT_LOCAL : ACT_REMOTE;
        match_res.out_protocol = r_rd.dst_protocol;
        match_res.out_code     = r_rd.dst_code;
        match_res.out_address  = r_rd.dst_address;
        match_res.last         = 1'b0;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && (i_q_item.kind == K_LOOKUP)) begin
                    n_state = BK_WALK;
                end else if (i_q_valid && (i_q_item.kind == K_REJECT)) begin
                    n_state = BK_REJECT;
                end
            end
            BK_WALK: begin
                if (walk_adv && (cap_hit || walk_done)) begin
                    n_state = BK_FLUSH;
                end
            end
            BK_FLUSH: begin
                if (!r_hold_vld || out_free) begin
                    n_state = BK_IDLE;
                end
            end
            BK_REJECT: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_q_pop    = 1'b0;
        walk_adv   = 1'b0;
        flush_out  = 1'b0;
        reject_out = 1'b0;
        unique case (r_state)
            BK_IDLE:   o_q_pop    = i_q_valid;
            // A new match can only be held once the previous one has left.
            BK_WALK:   walk_adv   = !(cmp_match && r_hold_vld && !out_free);
            BK_FLUSH:  flush_out  = r_hold_vld && out_free;
            BK_REJECT: reject_out = out_free;
            default:   o_q_pop    = 1'b0;
        endcase
    end

    assign rd_issue   = walk_adv && (r_idx < r_active);
    assign push_hold  = walk_adv && cmp_match && r_hold_vld;
    assign start_walk = o_q_pop && (i_q_item.kind == K_LOOKUP);
    assign do_begin   = o_q_pop && (i_q_item.kind == K_BEGIN);
    assign do_clear   = o_q_pop && (i_q_item.kind == K_CLEAR);
    assign do_entry   = o_q_pop && (i_q_item.kind == K_ENTRY) && r_loading;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_active   <= '0;
            r_pend     <= '0;
            r_wptr     <= '0;
            r_loading  <= 1'b0;
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_hold_vld <= 1'b0;
            r_nres     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_begin) begin
                r_pend    <= i_q_item.route_count[CNT_W-1:0];
                r_wptr    <= '0;
                r_loading <= 1'b1;
            end
            if (do_clear) begin
                r_active  <= '0;
                r_loading <= 1'b0;
            end
            if (do_entry) begin
                r_wptr <= wptr_inc;
                if (wptr_inc >= r_pend) begin
                    r_active  <= r_pend;
                    r_loading <= 1'b0;
                end
            end
            if (start_walk) begin
                r_idx      <= '0;
                r_rd_vld   <= 1'b0;
                r_nres     <= '0;
                r_hold_vld <= 1'b0;
            end
            if (walk_adv) begin
                r_rd_vld <= rd_issue;
                if (rd_issue) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (cmp_match) begin
                    r_hold_vld <= 1'b1;
                    r_nres     <= r_nres + 1'b1;
                end
            end
            if (flush_out) begin
                r_hold_vld <= 1'b0;
            end
            if (push_hold || flush_out || reject_out) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (start_walk) begin
            r_key_protocol <= i_q_item.route.src_protocol;
            r_key_code     <= i_q_item.route.src_code;
        end
        if (walk_adv && cmp_match) begin
            r_hold <= match_res;
        end
        if (push_hold) begin
            r_out <= r_hold;
        end else if (flush_out) begin
            r_out <= '{action: r_hold.action, out_protocol: r_hold.out_protocol,
                       out_code: r_hold.out_code, out_address: r_hold.out_address,
                       last: 1'b1};
        end else if (reject_out) begin
            r_out.action       <= ACT_REJECT;
            r_out.out_protocol <= '0;
            r_out.out_code     <= '0;
            r_out.out_address  <= '0;
            r_out.last         <= 1'b1;
        end
    end

    // Route table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (do_entry) begin
            r_mem[r_wptr[IDX_W-1:0]] <= i_q_item.route;
        end
        if (rd_issue) begin
            r_rd <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_IDLE) |-> !r_hold_vld)
        else $error("held result left over outside a lookup");
    a_load_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loading |-> (r_wptr < r_pend))
        else $error("write pointer passed the announced count");
    a_active_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= CNT_W'(ROUTE_CAPACITY))
        else $error("active count above capacity");
    a_res_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= RES_W'(MAX_RESULTS))
        else $error("lookup produced too many results");
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flush_out |=> (r_out_vld && r_out.last))
        else $error("final lookup result not marked last");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the IR code route table unit: a directed stimulus table,
// then random load, entry and lookup beats, scored against an in-bench route model or a typed answer.
// Depends on ircrt_pkg and ir_code_route_table_unit.
module tb_top;
    import ircrt_pkg::*;

    localparam int ROUTE_CAP     = ROUTE_CAPACITY_DEF;
    localparam int RANDOM_BEATS  = 450;
    // Cycles with no beat on either channel before the run is declared hung.
    // The worst honest stretch is a sender gap, a sink stall and a full table walk.
    localparam int STALL_LIMIT   = 4000;
    // A lookup that finds nothing leaves no trace in the result queue, so the end
    // of the run waits out one full table walk after the last result.
    localparam int SETTLE_CYCLES = ROUTE_CAP + 16;
    localparam int KEY_POOL      = 4;

    typedef struct packed {
        logic [31:0] proto;
        logic [63:0] code;
    } t_src_key;

    // One row of the directed table. A typed row carries its answer directly;
    // the others are scored against the route model.
    typedef struct {
        t_in_item  beat;
        bit        typed;
        bit        typed_hit;
        t_out_item typed_res;
    } t_plan_row;

    localparam t_out_item REJECT_RES = '{action: ACT_REJECT, out_protocol: 32'd0,
                                         out_code: 64'd0, out_address: 32'd0,
                                         last: 1'b1};
    localparam t_out_item NO_RES     = '0;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;

    ir_code_route_table_unit #(
        .ROUTE_CAPACITY(ROUTE_CAP)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_item (i_item),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_item (o_item)
    );

    // Route model state: the table itself, the count in force, the count being
    // loaded, the fill position and whether a load is open.
    t_route      route_mem [ROUTE_CAP];
    int unsigned live_count;
    int unsigned announced_count;
    int unsigned fill_ptr;
    bit          filling;

    // Results produced by the beat just modeled, and the running queue of
    // results still owed by the block, oldest first.
    t_out_item walk_hits[$];
    t_out_item route_results[$];

    int mismatch_count = 0;
    int counted_beats  = 0;

    // When set, that side runs back to back with no idle cycles.
    bit calm_send = 1'b0;
    bit calm_recv = 1'b0;

    // Small pool of source keys so that random entries and lookups actually collide.
    t_src_key key_pool [KEY_POOL];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Advances the route model by one accepted beat and leaves the results that
    // beat owes in walk_hits.
    function automatic void predict_beat(input t_in_item it);
        t_out_item hit;
        int        idx;
        walk_hits.delete();
        case (it.command)
            CMD_BEGIN: begin
                if (it.route_count > ROUTE_CAP) begin
                    // A refused count touches nothing, not even a load in progress.
                    walk_hits.push_back(REJECT_RES);
                end else if (it.route_count == 0) begin
                    live_count = 0;
                    filling    = 1'b0;
                end else begin
                    announced_count = it.route_count;
                    fill_ptr        = 0;
                    filling         = 1'b1;
                end
            end
            CMD_ENTRY: begin
                // An entry outside an open load is dropped.
                if (filling && fill_ptr < ROUTE_CAP) begin
                    route_mem[fill_ptr] = '{src_protocol: it.src_protocol,
                                            src_code:     it.src_code,
                                            dst_protocol: it.dst_protocol,
                                            dst_code:     it.dst_code,
                                            dst_address:  it.dst_ip};
                    fill_ptr++;
                    // The new count only takes effect with the last announced entry.
                    if (fill_ptr >= announced_count) begin
                        live_count = announced_count;
                        filling    = 1'b0;
                    end
                end
            end
            CMD_LOOKUP: begin
                // Walk the routes in force in order; a zero destination protocol
                // suppresses the match, a zero address makes it a local transmit.
                for (idx = 0; idx < live_count && walk_hits.size() < MAX_RESULTS; idx++) begin
                    if (route_mem[idx].src_protocol == it.src_protocol &&
                        route_mem[idx].src_code == it.src_code &&
                        route_mem[idx].dst_protocol != '0) begin
                        hit.action       = (route_mem[idx].dst_address == '0) ?
                                           ACT_LOCAL : ACT_REMOTE;
                        hit.out_protocol = route_mem[idx].dst_protocol;
                        hit.out_code     = route_mem[idx].dst_code;
                        hit.out_address  = route_mem[idx].dst_address;
                        hit.last         = 1'b0;
                        walk_hits.push_back(hit);
                    end
                end
                if (walk_hits.size() != 0) begin
                    walk_hits[walk_hits.size() - 1].last = 1'b1;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Scores one result beat against the oldest result still owed.
    function automatic void check_result(input t_out_item got);
        t_out_item want;
        if (route_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result beat, expected none, got %h", $time, got);
            return;
        end
        want = route_results.pop_front();
        compare_field("action", want.action, got.action);
        compare_field("out_protocol", want.out_protocol, got.out_protocol);
        compare_field("out_code", want.out_code, got.out_code);
        compare_field("out_address", want.out_address, got.out_address);
        compare_field("last", want.last, got.last);
    endfunction

    function automatic int unsigned pick_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item mk_beat(input logic [1:0] cmd, input logic [15:0] count,
                                         input t_src_key key, input logic [31:0] dproto,
                                         input logic [63:0] dcode, input logic [31:0] dip);
        t_in_item beat;
        beat.command      = cmd;
        beat.route_count  = count;
        beat.src_protocol = key.proto;
        beat.src_code     = key.code;
        beat.dst_protocol = dproto;
        beat.dst_code     = dcode;
        beat.dst_ip       = dip;
        return beat;
    endfunction

    // Mostly a pooled key, sometimes a fresh one that is unlikely to match.
    function automatic t_src_key pick_key();
        if ($urandom_range(0, 3) == 0) begin
            return {$urandom, $urandom, $urandom};
        end
        return key_pool[$urandom_range(0, KEY_POOL - 1)];
    endfunction

    // New pool of keys, with the all-zero and all-ones keys turning up now and then.
    function automatic void refresh_pool();
        int unsigned flavor;
        foreach (key_pool[p]) begin
            flavor = $urandom_range(0, 7);
            if (flavor == 0) begin
                key_pool[p] = '0;
            end else if (flavor == 1) begin
                key_pool[p] = '1;
            end else begin
                key_pool[p] = {$urandom, $urandom, $urandom};
            end
        end
    endfunction

    // Route entry with random destination; suppressed and local routes are common.
    function automatic t_in_item random_entry(input t_src_key key);
        logic [31:0] dproto;
        logic [31:0] dip;
        dproto = ($urandom_range(0, 6) == 0) ? 32'd0 : $urandom;
        dip    = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        return mk_beat(CMD_ENTRY, 16'($urandom), key, dproto, rand64(), dip);
    endfunction

    // Presents one input beat after a random gap and holds it until accepted.
    // The task returns at the accepting edge with valid still high, so the next
    // call either replaces the beat in the same step or lowers valid first.
    task automatic send_beat(input t_in_item beat, input bit typed, input bit typed_hit,
                             input t_out_item typed_res);
        int unsigned gap;
        bit          ignored;
        gap = pick_gap(calm_send);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= beat;
        do @(posedge i_clk); while (!o_ready);
        // Beats the block merely drops do not count toward the random budget.
        ignored = (beat.command == CMD_RSVD) || (beat.command == CMD_ENTRY && !filling);
        if (!ignored) begin
            counted_beats++;
        end
        predict_beat(beat);
        if (typed) begin
            if (typed_hit) begin
                route_results.push_back(typed_res);
            end
        end else begin
            foreach (walk_hits[k]) begin
                route_results.push_back(walk_hits[k]);
            end
        end
    endtask

    // Holds the input side idle until every owed result has come back.
    task automatic drain_results();
        if (route_results.size() != 0) begin
            i_valid <= 1'b0;
            while (route_results.size() != 0) @(posedge i_clk);
        end
    endtask

    // Result sink: stalls a random number of cycles before each beat, then takes
    // the next result beat and scores it.
    initial begin : result_sink
        int unsigned stall;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = pick_gap(calm_recv);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            check_result(o_item);
        end
    end

    // Hang detector: counts cycles in which neither channel moves a beat.
    initial begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_run = 0;
            end else begin
                idle_run++;
            end
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        t_plan_row   plan[$];
        t_src_key    key_lo;
        t_src_key    key_hi;
        t_in_item    beat;
        int unsigned beat_goal;
        int unsigned choice;
        int unsigned size_pick;
        int unsigned n;
        int unsigned stop_at;

        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item  <= '0;
        live_count      = 0;
        announced_count = 0;
        fill_ptr        = 0;
        filling         = 1'b0;
        key_lo = '0;
        key_hi = '1;

        // Directed table. The table is built before reset is released, then sent in order.
        // Right after reset no route is in force, so a lookup finds nothing.
        plan.push_back('{mk_beat(CMD_LOOKUP, 16'h0000, key_hi, '0, '0, '0),
                         1'b1, 1'b0, NO_RES});
        // Counts above capacity are refused: the largest count and one past capacity.
        plan.push_back('{mk_beat(CMD_BEGIN, 16'hFFFF, key_lo, '0, '0, '0),
                         1'b1, 1'b1, REJECT_RES});
        plan.push_back('{mk_beat(CMD_BEGIN, 16'(ROUTE_CAP + 1), key_hi, '1, '1, '1),
                         1'b1, 1'b1, REJECT_RES});
        // The unused command code and an entry with no load open are dropped.
        plan.push_back('{mk_beat(CMD_RSVD, 16'hFFFF, key_hi, '1, '1, '1),
                         1'b1, 1'b0, NO_RES});
        plan.push_back('{mk_beat(CMD_ENTRY, 16'hFFFF, key_hi, '1, '1, '1),
                         1'b1, 1'b0, NO_RES});
        // A load at exactly capacity is opened, then restarted as a three-route load.
        plan.push_back('{mk_beat(CMD_BEGIN, 16'(ROUTE_CAP), key_lo, '0, '0, '0),
                         1'b1, 1'b0, NO_RES});
        plan.push_back('{mk_beat(CMD_BEGIN, 16'd3, key_lo, '0, '0, '0),
                         1'b1, 1'b0, NO_RES});
        // Route 0: all-zero key, local transmit.
        plan.push_back('{mk_beat(CMD_ENTRY, 16'd0, key_lo, 32'd1, '1, 32'd0),
                         1'b0, 1'b0, NO_RES});
        // A refused count in the middle of a load must leave that load running.
        plan.push_back('{mk_beat(CMD_BEGIN, 16'(ROUTE_CAP + 1), key_lo, '0, '0, '0),
                         1'b1, 1'b1, REJECT_RES});
        // While loading, the old (empty) route set stays in force.
        plan.push_back('{mk_beat(CMD_LOOKUP, 16'd0, key_lo, '0, '0, '0),
                         1'b0, 1'b0, NO_RES});
        // Route 1 is suppressed by its zero destination protocol.
        plan.push_back('{mk_beat(CMD_ENTRY, 16'd0, key_lo, 32'd0, 64'd5, 32'd1),
                         1'b0, 1'b0, NO_RES});
        // Route 2: remote transmit with all-ones destination protocol and address.
        plan.push_back('{mk_beat(CMD_ENTRY, 16'd0, key_lo, '1, 64'd0, '1),
                         1'b0, 1'b0, NO_RES});
        // The load is complete: one local and one remote result, then no match.
        plan.push_back('{mk_beat(CMD_LOOKUP, 16'd0, key_lo, '0, '0, '0),
                         1'b0, 1'b0, NO_RES});
        plan.push_back('{mk_beat(CMD_LOOKUP, 16'd0, key_hi, '0, '0, '0),
                         1'b0, 1'b0, NO_RES});
        // A two-route load over the top of the three routes in force.
        plan.push_back('{mk_beat(CMD_BEGIN, 16'd2, key_hi, '0, '0, '0),
                         1'b1, 1'b0, NO_RES});
        plan.push_back('{mk_beat(CMD_ENTRY, 16'd0, key_hi, 32'h11,
                                 64'h0123_4567_89AB_CDEF, 32'h0100_007F),
                         1'b0, 1'b0, NO_RES});
        // Mid-load lookup: route 0 is already overwritten, routes 1 and 2 are old.
        plan.push_back('{mk_beat(CMD_LOOKUP, 16'd0, key_lo, '0, '0, '0),
                         1'b0, 1'b0, NO_RES});
        plan.push_back('{mk_beat(CMD_ENTRY, 16'd0, key_hi, 32'd7,
                                 64'hFEDC_BA98_7654_3210, 32'd0),
                         1'b0, 1'b0, NO_RES});
        plan.push_back('{mk_beat(CMD_LOOKUP, 16'd0, key_hi, '0, '0, '0),
                         1'b0, 1'b0, NO_RES});
        // An empty load clears the table at once; nothing matches afterwards and a
        // following entry is stray.
        plan.push_back('{mk_beat(CMD_BEGIN, 16'd0, key_lo, '0, '0, '0),
                         1'b1, 1'b0, NO_RES});
        plan.push_back('{mk_beat(CMD_LOOKUP, 16'd0, key_hi, '0, '0, '0),
                         1'b1, 1'b0, NO_RES});
        plan.push_back('{mk_beat(CMD_ENTRY, 16'd1, key_hi, '1, '1, '1),
                         1'b1, 1'b0, NO_RES});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            send_beat(plan[r].beat, plan[r].typed, plan[r].typed_hit, plan[r].typed_res);
        end

        // Random part. It opens with a full table that shares one key, so a single
        // lookup returns a result from every route and hits the result limit.
        refresh_pool();
        beat_goal = counted_beats + RANDOM_BEATS;
        send_beat(mk_beat(CMD_BEGIN, 16'(ROUTE_CAP), pick_key(), $urandom, rand64(), $urandom),
                  1'b0, 1'b0, NO_RES);
        repeat (ROUTE_CAP) begin
            beat = random_entry(key_pool[0]);
            if (beat.dst_protocol == '0) begin
                beat.dst_protocol = 32'd1;
            end
            send_beat(beat, 1'b0, 1'b0, NO_RES);
        end
        send_beat(mk_beat(CMD_LOOKUP, 16'($urandom), key_pool[0], $urandom, rand64(),
                          $urandom), 1'b0, 1'b0, NO_RES);
        // Let the whole burst of results come back before going on.
        drain_results();

        while (counted_beats < beat_goal) begin
            // Either side switches now and then between random idling and none.
            if ($urandom_range(0, 7) == 0) calm_send = ~calm_send;
            if ($urandom_range(0, 7) == 0) calm_recv = ~calm_recv;
            if ($urandom_range(0, 9) == 0) refresh_pool();
            choice = $urandom_range(0, 99);
            if (choice < 55) begin
                // Well-formed load: mostly small, a few at full capacity, some empty.
                // About one in seven is cut short and left to the next begin-load.
                size_pick = $urandom_range(0, 99);
                if (size_pick < 78) begin
                    n = $urandom_range(1, 6);
                end else if (size_pick < 92) begin
                    n = $urandom_range(7, 24);
                end else if (size_pick < 97) begin
                    n = ROUTE_CAP;
                end else begin
                    n = 0;
                end
                stop_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, n) : n;
                send_beat(mk_beat(CMD_BEGIN, 16'(n), pick_key(), $urandom, rand64(),
                                  $urandom), 1'b0, 1'b0, NO_RES);
                repeat (stop_at) begin
                    // Lookups slipped into the load see a mix of old and new routes.
                    if ($urandom_range(0, 4) == 0) begin
                        send_beat(mk_beat(CMD_LOOKUP, 16'($urandom), pick_key(), $urandom,
                                          rand64(), $urandom), 1'b0, 1'b0, NO_RES);
                    end
                    send_beat(random_entry(pick_key()), 1'b0, 1'b0, NO_RES);
                end
            end else if (choice < 85) begin
                send_beat(mk_beat(CMD_LOOKUP, 16'($urandom), pick_key(), $urandom,
                                  rand64(), $urandom), 1'b0, 1'b0, NO_RES);
            end else begin
                // Noise: the unused code, refused counts and stray entries.
                case ($urandom_range(0, 2))
                    0: beat = mk_beat(CMD_RSVD, 16'($urandom), pick_key(), $urandom,
                                      rand64(), $urandom);
                    1: beat = mk_beat(CMD_BEGIN, 16'($urandom_range(ROUTE_CAP + 1, 65535)),
                                      pick_key(), $urandom, rand64(), $urandom);
                    default: beat = random_entry(pick_key());
                endcase
                send_beat(beat, 1'b0, 1'b0, NO_RES);
            end
            if ($urandom_range(0, 19) == 0) begin
                drain_results();
            end
        end

        // Wind down: stop sending, collect what is owed, then give a last lookup
        // time to show any result it should not have produced.
        i_valid <= 1'b0;
        while (route_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && route_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
